// File: design/jcrd_pkg.sv
package jcrd_pkg;

  // Default number of color components that keep a DC predictor.
  localparam int NumComponentsDef = 3;

  // Field widths.
  localparam int CompW = 2;
  localparam int SymW  = 8;
  localparam int BitsW = 15;
  localparam int PosW  = 6;
  localparam int ValW  = 16;

  // Block layout and special symbols.
  localparam logic [PosW:0]   BlockCoefs = 7'd64;
  localparam logic [PosW:0]   LastCoef   = 7'd63;
  localparam logic [PosW:0]   ZrlRun     = 7'd16;
  localparam logic [SymW-1:0] SymEob     = 8'h00;
  localparam logic [SymW-1:0] SymZrl     = 8'hF0;

  typedef struct packed {
    logic             scan_start;
    logic [CompW-1:0] component;
    logic [SymW-1:0]  symbol;
    logic [BitsW-1:0] extra_bits;
  } item_t;

  typedef struct packed {
    logic [PosW-1:0]        coef_index;
    logic signed [ValW-1:0] coef_value;
    logic                   coef_valid;
    logic                   block_end;
    logic                   error;
  } result_t;

  // State changes that one symbol causes.
  typedef struct packed {
    logic [PosW-1:0]        pos_nxt;
    logic                   dc_write;
    logic signed [ValW-1:0] dc_value;
  } state_upd_t;

  // JPEG magnitude extension: the low size bits, and a leading zero means
  // a negative value of the form v - (2^size - 1). Size zero gives zero.
  function automatic logic signed [ValW-1:0] extend_bits(
    input logic [BitsW-1:0] bits,
    input logic [3:0]       size
  );
    logic [ValW-1:0] mask;
    logic [ValW-1:0] v;
    logic [3:0]      msb;
    mask = '0;
    v    = '0;
    msb  = size - 4'd1;
    if (size == 4'd0) begin
      return '0;
    end
    mask = ValW'((17'd1 << size) - 17'd1);
    v    = {1'b0, bits} & mask;
    if (v[msb] == 1'b0) begin
      return signed'(v - mask);
    end
    return signed'(v);
  endfunction

endpackage

// File: design/jcrd_core.sv
module jcrd_core
  import jcrd_pkg::*;
(
  input  item_t                  item,
  input  logic [PosW-1:0]        pos,
  input  logic signed [ValW-1:0] pred,
  input  logic                   comp_ok,
  output result_t                res,
  output state_upd_t             upd
);

  logic [3:0]             size;
  logic [3:0]             run;
  logic signed [ValW-1:0] diff;
  logic signed [ValW:0]   dc_sum;
  logic signed [ValW-1:0] dc_val;
  logic [PosW:0]          zrl_pos;
  logic [PosW:0]          run_pos;

  assign size    = item.symbol[3:0];
  assign run     = item.symbol[7:4];
  assign diff    = extend_bits(item.extra_bits, size);
  assign zrl_pos = {1'b0, pos} + ZrlRun;
  assign run_pos = {1'b0, pos} + {3'b000, run};

  // DC sum saturates to the signed 16-bit range.
  always_comb begin
    dc_sum = (ValW+1)'(pred) + (ValW+1)'(diff);
    if (dc_sum > 17'sd32767) begin
      dc_val = 16'sh7FFF;
    end else if (dc_sum < -17'sd32768) begin
      dc_val = 16'sh8000;
    end else begin
      dc_val = dc_sum[ValW-1:0];
    end
  end

  // Symbol decode: DC first, then EOB, ZRL or run/size.
  always_comb begin
    res          = '0;
    upd.pos_nxt  = '0;
    upd.dc_write = 1'b0;
    upd.dc_value = dc_val;
    if (pos == '0) begin
      res.coef_value = dc_val;
      res.coef_valid = 1'b1;
      upd.pos_nxt    = PosW'(1);
      upd.dc_write   = comp_ok;
    end else if (item.symbol == SymEob) begin
      res.block_end = 1'b1;
    end else if (item.symbol == SymZrl) begin
      if (zrl_pos > BlockCoefs) begin
        res.block_end = 1'b1;
        res.error     = 1'b1;
      end else if (zrl_pos == BlockCoefs) begin
        res.block_end = 1'b1;
      end else begin
        upd.pos_nxt = zrl_pos[PosW-1:0];
      end
    end else if (run_pos >= BlockCoefs) begin
      res.block_end = 1'b1;
      res.error     = 1'b1;
    end else begin
      res.coef_index = run_pos[PosW-1:0];
      res.coef_value = diff;
      res.coef_valid = 1'b1;
      if (run_pos == LastCoef) begin
        res.block_end = 1'b1;
      end else begin
        upd.pos_nxt = run_pos[PosW-1:0] + PosW'(1);
      end
    end
  end

endmodule

// File: design/jpeg_coefficient_run_decoder_top.sv
// A result is offered once its input has moved through the input register,
// then the result register. Throughput: one symbol per cycle while out_ready
// is high; the block position and DC predictors update in the same cycle a
// symbol moves into the result register.
// Reset (synchronous, active low) empties both registers, clears all DC
// predictors and sets the block position to expect a DC symbol.
module jpeg_coefficient_run_decoder_top
  import jcrd_pkg::*;
#(
  parameter int NUM_COMPONENTS = NumComponentsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_scan_start,
  input  logic [CompW-1:0]       in_component,
  input  logic [SymW-1:0]        in_symbol,
  input  logic [BitsW-1:0]       in_extra_bits,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PosW-1:0]        out_coef_index,
  output logic signed [ValW-1:0] out_coef_value,
  output logic                   out_coef_valid,
  output logic                   out_block_end,
  output logic                   out_error
);

  logic                   s1_valid_r;
  item_t                  s1_item_r;
  logic                   out_valid_r;
  result_t                out_res_r;
  logic [PosW-1:0]        pos_r;
  logic signed [ValW-1:0] pred_r [NUM_COMPONENTS];

  logic                   out_load;
  logic                   s1_adv;
  logic [PosW-1:0]        pos_eff;
  logic signed [ValW-1:0] pred_sel;
  logic                   comp_ok;
  result_t                res;
  state_upd_t             upd;

  // Handshake: the result register takes a new result when empty or drained.
  assign out_load = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;

  // Scan start clears position and predictors ahead of this symbol.
  assign pos_eff = s1_item_r.scan_start ? '0 : pos_r;
  assign comp_ok = int'(s1_item_r.component) < NUM_COMPONENTS;

  always_comb begin
    pred_sel = '0;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      if (s1_item_r.component == CompW'(i)) begin
        pred_sel = pred_r[i];
      end
    end
    if (s1_item_r.scan_start) begin
      pred_sel = '0;
    end
  end

  jcrd_core u_core (
    .item    (s1_item_r),
    .pos     (pos_eff),
    .pred    (pred_sel),
    .comp_ok (comp_ok),
    .res     (res),
    .upd     (upd)
  );

  // Valid flags and decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        pred_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        pos_r <= upd.pos_nxt;
        for (int i = 0; i < NUM_COMPONENTS; i++) begin
          if (upd.dc_write && s1_item_r.component == CompW'(i)) begin
            pred_r[i] <= upd.dc_value;
          end else if (s1_item_r.scan_start) begin
            pred_r[i] <= '0;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r.scan_start <= in_scan_start;
      s1_item_r.component  <= in_component;
      s1_item_r.symbol     <= in_symbol;
      s1_item_r.extra_bits <= in_extra_bits;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coef_index = out_res_r.coef_index;
  assign out_coef_value = out_res_r.coef_value;
  assign out_coef_valid = out_res_r.coef_valid;
  assign out_block_end  = out_res_r.block_end;
  assign out_error      = out_res_r.error;

  // An error always closes the block and carries no coefficient.
  a_error_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.error |-> out_res_r.block_end && !out_res_r.coef_valid)
    else $error("error result without block end or with a coefficient");

  // Results without a coefficient report index and value zero.
  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.coef_valid |->
      out_res_r.coef_index == '0 && out_res_r.coef_value == '0)
    else $error("result without coefficient has nonzero index or value");

  // Index zero is the DC coefficient, which never ends a block.
  a_dc_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.coef_valid && out_res_r.coef_index == '0 |->
      !out_res_r.block_end && !out_res_r.error)
    else $error("DC coefficient flagged as block end");

  // After a symbol ends a block, the next symbol is taken as DC.
  a_end_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res.block_end |=> pos_r == '0)
    else $error("block position not cleared after block end");

  // A transfer into the result register always brings a valid result.
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result register empty after a transfer");

endmodule

// File: test/jpeg_coefficient_run_decoder_top_tb.sv
`timescale 1ns / 1ps

module jpeg_coefficient_run_decoder_top_tb;
  import jcrd_pkg::*;

  localparam int NumComp       = NumComponentsDef;
  localparam int RandomSymbols = 1150;
  localparam int CycleLimit    = 200000;
  localparam int DrainCycles   = 8;

  logic                   clk = 1'b1;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_scan_start = 1'b0;
  logic [CompW-1:0]       in_component = '0;
  logic [SymW-1:0]        in_symbol = '0;
  logic [BitsW-1:0]       in_extra_bits = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PosW-1:0]        out_coef_index;
  logic signed [ValW-1:0] out_coef_value;
  logic                   out_coef_valid;
  logic                   out_block_end;
  logic                   out_error;

  jpeg_coefficient_run_decoder_top #(
    .NUM_COMPONENTS(NumComp)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_scan_start  (in_scan_start),
    .in_component   (in_component),
    .in_symbol      (in_symbol),
    .in_extra_bits  (in_extra_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_coef_index (out_coef_index),
    .out_coef_value (out_coef_value),
    .out_coef_valid (out_coef_valid),
    .out_block_end  (out_block_end),
    .out_error      (out_error)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Symbols waiting to be driven and coefficients waiting to come out.
  item_t   symbol_queue[$];
  result_t coef_expected[$];

  // Decoder state as the testbench tracks it.
  logic signed [ValW-1:0] dc_pred[NumComp];
  int unsigned            blk_pos;

  int unsigned cycle = 0;
  int unsigned stim_count = 0;
  int unsigned sent_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned hold_cycles = 0;
  int unsigned stall_cycles = 0;
  int unsigned seen_coefs = 0;
  int unsigned seen_ends = 0;
  int unsigned seen_errors = 0;
  int unsigned seen_results = 0;
  item_t       drive_item;
  item_t       taken_item;
  result_t     want;

  // Count cycles and stop a run that hangs.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycle,
               coef_expected.size());
      $display("jpeg_coefficient_run_decoder_top_tb: done, errors");
      $finish;
    end
  end

  // Wait cycles for either side; some stretches run with no idling at all.
  function automatic int unsigned draw_wait();
    if ((cycle / 300) % 4 == 0) begin
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  // JPEG magnitude: the low nbits of raw, a leading zero marks a negative value.
  function automatic int magnitude_value(input logic [BitsW-1:0] raw, input int unsigned nbits);
    int unsigned span;
    int unsigned v;
    if (nbits == 0) begin
      return 0;
    end
    span = (32'd1 << nbits) - 1;
    v = raw & span;
    if ((v >> (nbits - 1)) == 0) begin
      return int'(v) - int'(span);
    end
    return int'(v);
  endfunction

  function automatic void clear_scan();
    for (int i = 0; i < NumComp; i++) begin
      dc_pred[i] = '0;
    end
    blk_pos = 0;
  endfunction

  // Works out the coefficient a symbol yields and advances the tracked state.
  function automatic result_t decode_symbol(input item_t it);
    result_t     r;
    int unsigned pos;
    int unsigned nbits;
    int          sum;
    r = '0;
    nbits = it.symbol[3:0];
    if (it.scan_start) begin
      clear_scan();
    end
    pos = (blk_pos >= BlockCoefs) ? 0 : blk_pos;

    if (pos == 0) begin
      // DC: the difference is added to the component's predictor and clamped.
      sum = magnitude_value(it.extra_bits, nbits);
      if (it.component < NumComp) begin
        sum += dc_pred[it.component];
      end
      if (sum > 32767) begin
        sum = 32767;
      end else if (sum < -32768) begin
        sum = -32768;
      end
      if (it.component < NumComp) begin
        dc_pred[it.component] = sum[ValW-1:0];
      end
      blk_pos = 1;
      r.coef_value = sum[ValW-1:0];
      r.coef_valid = 1'b1;
    end else if (it.symbol == SymEob) begin
      blk_pos = 0;
      r.block_end = 1'b1;
    end else if (it.symbol == SymZrl) begin
      // Sixteen zeros; landing exactly on the block end is legal.
      pos += ZrlRun;
      if (pos >= BlockCoefs) begin
        blk_pos = 0;
        r.block_end = 1'b1;
        r.error = (pos > BlockCoefs);
      end else begin
        blk_pos = pos;
      end
    end else begin
      pos += it.symbol[7:4];
      if (pos >= BlockCoefs) begin
        blk_pos = 0;
        r.block_end = 1'b1;
        r.error = 1'b1;
      end else begin
        r.coef_index = pos[PosW-1:0];
        r.coef_value = ValW'(magnitude_value(it.extra_bits, nbits));
        r.coef_valid = 1'b1;
        r.block_end = (pos == LastCoef);
        blk_pos = (pos == LastCoef) ? 0 : pos + 1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d result %0d: %s", cycle, seen_results, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_val));
    end
  endtask

  task automatic add_item(input logic start, input int unsigned comp,
                          input logic [SymW-1:0] sym, input logic [BitsW-1:0] bits);
    item_t it;
    it.scan_start = start;
    it.component  = comp[CompW-1:0];
    it.symbol     = sym;
    it.extra_bits = bits;
    symbol_queue.insert(symbol_queue.size(), it);
    stim_count++;
  endtask

  // One block: a DC symbol, then AC symbols that mostly stay inside the block,
  // with some arbitrary symbols and rare mid-block scan restarts mixed in.
  task automatic add_random_block();
    int unsigned comp;
    int unsigned gpos;
    int unsigned pick;
    int unsigned run;
    int unsigned nbits;
    logic [SymW-1:0] sym;
    bit closed;
    comp = ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, NumComp - 1);
    add_item($urandom_range(0, 24) == 0, comp, SymW'($urandom_range(0, 255)),
             BitsW'($urandom_range(0, 32767)));
    gpos = 1;
    closed = 1'b0;
    while (!closed) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        sym = SymEob;
      end else if (pick < 14) begin
        sym = SymZrl;
      end else if (pick < 18) begin
        sym = SymW'($urandom_range(0, 255));
      end else begin
        run = $urandom_range(0, (63 - gpos < 15) ? 63 - gpos : 15);
        nbits = $urandom_range(0, 15);
        if (nbits == 0 && (run == 0 || run == 15)) begin
          nbits = 1;
        end
        sym = {run[3:0], nbits[3:0]};
      end
      add_item($urandom_range(0, 199) == 0, comp, sym,
               BitsW'($urandom_range(0, 32767)));
      if (sym == SymEob) begin
        closed = 1'b1;
      end else begin
        gpos += sym[7:4] + 1;
        closed = (gpos >= BlockCoefs);
      end
    end
  endtask

  // Driver: presents queued symbols and predicts each one on its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken_item.scan_start = in_scan_start;
        taken_item.component  = in_component;
        taken_item.symbol     = in_symbol;
        taken_item.extra_bits = in_extra_bits;
        coef_expected.insert(coef_expected.size(), decode_symbol(taken_item));
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (hold_cycles > 0) begin
          hold_cycles--;
          in_valid <= 1'b0;
        end else if (symbol_queue.size() != 0) begin
          drive_item = symbol_queue.pop_front();
          in_scan_start <= drive_item.scan_start;
          in_component  <= drive_item.component;
          in_symbol     <= drive_item.symbol;
          in_extra_bits <= drive_item.extra_bits;
          in_valid      <= 1'b1;
          hold_cycles = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_results++;
        if (coef_expected.size() == 0) begin
          report_mismatch("result arrived with none expected");
        end else begin
          want = coef_expected.pop_front();
          check_field("coef_index", out_coef_index, want.coef_index);
          check_field("coef_value", out_coef_value, $signed(want.coef_value));
          check_field("coef_valid", out_coef_valid, want.coef_valid);
          check_field("block_end", out_block_end, want.block_end);
          check_field("error", out_error, want.error);
        end
        seen_coefs  += out_coef_valid;
        seen_ends   += out_block_end;
        seen_errors += out_error;
        stall_cycles = draw_wait();
        out_ready <= (stall_cycles == 0);
      end else if (stall_cycles > 0) begin
        stall_cycles--;
        out_ready <= (stall_cycles == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    clear_scan();

    // Directed: size zero DC, full-scale DC and AC, ZRL, last coefficient.
    add_item(1'b1, 0, 8'h00, 15'h0000);
    add_item(1'b0, 0, SymEob, 15'h0000);
    add_item(1'b0, 0, 8'h0F, 15'h7FFF);
    add_item(1'b0, 0, 8'h0F, 15'h0000);
    add_item(1'b0, 0, SymZrl, 15'h0000);
    add_item(1'b0, 0, 8'hFF, 15'h7FFF);
    add_item(1'b0, 0, SymZrl, 15'h1234);
    add_item(1'b0, 0, 8'hD1, 15'h0001);
    // Positive DC saturation, then ZRL running past the block end.
    add_item(1'b0, 0, 8'h0F, 15'h7FFF);
    add_item(1'b0, 0, SymZrl, 15'h0000);
    add_item(1'b0, 0, SymZrl, 15'h0000);
    add_item(1'b0, 0, SymZrl, 15'h0000);
    add_item(1'b0, 0, SymZrl, 15'h0000);
    // ZRL landing exactly on the block end.
    add_item(1'b0, 1, 8'h0F, 15'h0000);
    add_item(1'b0, 1, 8'hE1, 15'h0000);
    add_item(1'b0, 1, SymZrl, 15'h0000);
    add_item(1'b0, 1, SymZrl, 15'h0000);
    add_item(1'b0, 1, SymZrl, 15'h0000);
    // Negative DC saturation, then a run/size whose run overshoots.
    add_item(1'b0, 1, 8'h0F, 15'h0000);
    add_item(1'b0, 1, SymZrl, 15'h0000);
    add_item(1'b0, 1, SymZrl, 15'h0000);
    add_item(1'b0, 1, SymZrl, 15'h0000);
    add_item(1'b0, 1, 8'hF5, 15'h001F);
    // Component out of range, scan restart mid-block, AC of size zero.
    add_item(1'b0, 3, 8'h85, 15'h0010);
    add_item(1'b0, 3, SymEob, 15'h0000);
    add_item(1'b0, 3, 8'h00, 15'h7FFF);
    add_item(1'b1, 2, 8'h12, 15'h0000);
    add_item(1'b0, 2, 8'h50, 15'h7FFF);
    add_item(1'b0, 2, SymEob, 15'h0000);

    while (stim_count < RandomSymbols) begin
      add_random_block();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < stim_count) begin
      @(posedge clk);
    end
    while (coef_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Decoded %0d symbols in %0d cycles: %0d coefficients, %0d block ends,",
             sent_count, cycle, seen_coefs, seen_ends);
    $display("%0d run overflows, %0d mismatches", seen_errors, mismatch_count);
    if (mismatch_count == 0) begin
      $display("jpeg_coefficient_run_decoder_top_tb: done, clean");
    end else begin
      $display("jpeg_coefficient_run_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
